@@ rtl/sac_pkg.sv @@
package sac_pkg;

    // Fixed sizes of the block
    localparam int MAX_WINDOW = 16;
    localparam int MAX_POINTS = 8;
    localparam int ADC_BITS   = 12;

    localparam int WIN_W    = 5;
    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int SUM_W    = ADC_BITS + $clog2(MAX_WINDOW);
    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int PCNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DIV_N    = 64;
    localparam int DIV_D    = 33;
    localparam int DIV_CW   = $clog2(DIV_N + 1);
    localparam int MUL_W    = 33;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_POINT  = 2'd1,
        OP_COEF   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_WINDOW      = 3'd0,
        CFG_VPC         = 3'd1,
        CFG_MODE        = 3'd2,
        CFG_SCALE       = 3'd3,
        CFG_SLOPE       = 3'd4,
        CFG_OFFSET      = 3'd5,
        CFG_POINT_COUNT = 3'd6,
        CFG_POLY_DEGREE = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_GAIN   = 3'd1,
        MODE_LINEAR = 3'd2,
        MODE_PWL    = 3'd3,
        MODE_POLY   = 3'd4
    } cal_mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RING,
        S_VMUL,
        S_VDIV,
        S_VWAIT,
        S_MAP,
        S_M12,
        S_PL_FIRST,
        S_PL_LAST,
        S_PL_SCAN,
        S_PL_DX,
        S_PL_DWAIT,
        S_PL_MUL,
        S_PL_FIN,
        S_P_CMUL,
        S_P_CACC,
        S_P_XMUL,
        S_P_XUPD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        sample;
        logic [2:0]         entry_index;
        logic signed [31:0] raw_point;
        logic signed [31:0] known_point;
        logic signed [31:0] coefficient;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] calibrated_value;
        logic signed [31:0] voltage;
        logic               saturated;
    } out_item_t;

    // Clip to signed 32 bits; top bit is the clip flag
    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (x < -64'sh0000_0000_8000_0000)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, x[31:0]};
        return r;
    endfunction

    // Q16.16 product: round half up, floor toward minus infinity
    function automatic logic signed [63:0] mulq(input logic signed [65:0] p);
        logic signed [65:0] r;
        r = (p + 66'sd32768) >>> 16;
        return r[63:0];
    endfunction

endpackage

@@ rtl/sac_mul.sv @@
module sac_mul
    import sac_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [2*MUL_W-1:0] p
);

    logic signed [2*MUL_W-1:0] p_reg;

    // Register every product
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ rtl/sac_div.sv @@
module sac_div
    import sac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_N-1:0]  dividend,
    input  logic [DIV_D-1:0]  divisor,
    output logic [DIV_N-1:0]  quotient,
    output logic              done
);

    logic [DIV_N-1:0]  dvd_reg;
    logic [DIV_D:0]    rem_reg;
    logic [DIV_D-1:0]  dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_D:0]    rem_sh;
    logic              fits;

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh = {rem_reg[DIV_D-1:0], dvd_reg[DIV_N-1]};
        fits   = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits fill in from the bottom of the dividend word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[DIV_N-2:0], fits};
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

@@ rtl/sensor_average_calibrate_unit.sv @@
// Moving average of ADC samples followed by a calibration map, all in fixed
// point. Each sample beat yields one result beat (calibrated value, averaged
// Q16.16 voltage, clip flag); point and coefficient beats load the tables
// and give no result. In every mode a sample passes through the 64-step
// shared divider that forms the average; mode 3 can add a segment scan and
// a second divide, and mode 4 adds a power series on the shared multiplier.
// The input stalls while an item is in work and while a finished result
// waits for the sink.
module sensor_average_calibrate_unit
    import sac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration
    logic [WIN_W-1:0]   win_reg;
    logic [31:0]        vpc_reg;
    logic [2:0]         mode_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] slope_reg;
    logic signed [31:0] offset_reg;
    logic [3:0]         pcount_reg;
    logic [2:0]         pdeg_reg;

    // Tables
    logic signed [31:0] raw_tab_reg   [MAX_POINTS];
    logic signed [31:0] known_tab_reg [MAX_POINTS];
    logic signed [31:0] coef_tab_reg  [MAX_POINTS];

    // Averaging ring
    logic [ADC_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [ADC_BITS-1:0] ring_q_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                full_reg, full_next;
    logic [SLOT_W-1:0]   slot_eff;
    logic [WIN_W-1:0]    slot_inc;
    logic                ring_rd;
    logic                ring_we;

    // Sequencer
    state_t              state_reg, state_next;
    logic [ADC_BITS-1:0] sample_reg, sample_next;
    logic [WIN_W-1:0]    count_reg, count_next;
    logic [31:0]         volt_reg, volt_next;
    logic                flag_reg, flag_next;
    logic signed [31:0]  res_reg, res_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic signed [31:0]  prev_x_reg, prev_x_next;
    logic signed [31:0]  prev_y_reg, prev_y_next;
    logic signed [31:0]  hi_x_reg, hi_x_next;
    logic signed [31:0]  hi_y_reg, hi_y_next;
    logic [30:0]         t_reg, t_next;
    logic signed [31:0]  acc_reg, acc_next;
    logic signed [31:0]  xp_reg, xp_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    // Shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                      div_start;
    logic [DIV_N-1:0]          div_dvd;
    logic [DIV_D-1:0]          div_dvs;
    logic [DIV_N-1:0]          div_q;
    logic                      div_done;

    // Work values
    logic                accept;
    logic [PCNT_W-1:0]   npts;
    logic [IDX_W-1:0]    rd_idx;
    logic signed [31:0]  rd_x, rd_y, rd_c;
    logic signed [32:0]  v33;
    logic [48:0]         vnum;
    logic signed [32:0]  dx, dy, dv;
    logic [31:0]         ady;
    logic [63:0]         m_round;
    logic signed [63:0]  wide;
    logic [32:0]         sat_r;
    logic [WIN_W-1:0]    win_wr;

    sac_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    sac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign npts = (pcount_reg > PCNT_W'(MAX_POINTS)) ? PCNT_W'(MAX_POINTS)
                                                      : pcount_reg[PCNT_W-1:0];
    assign slot_eff = ({1'b0, slot_reg} >= win_reg) ? '0 : slot_reg;
    assign slot_inc = {1'b0, slot_eff} + 1'b1;
    assign v33      = {volt_reg[31], volt_reg};
    assign rd_x     = raw_tab_reg[rd_idx];
    assign rd_y     = known_tab_reg[rd_idx];
    assign rd_c     = coef_tab_reg[rd_idx];
    assign dx       = {hi_x_reg[31], hi_x_reg} - {prev_x_reg[31], prev_x_reg};
    assign dy       = {hi_y_reg[31], hi_y_reg} - {prev_y_reg[31], prev_y_reg};
    assign dv       = v33 - {prev_x_reg[31], prev_x_reg};
    assign ady      = dy[32] ? 32'(-dy) : dy[31:0];
    assign vnum     = mul_p[48:0] + {37'b0, count_reg, 7'b0};
    assign m_round  = 64'((mul_p + 66'sd536870912) >>> 30);

    always_comb
    begin
        win_wr = cfg_data[WIN_W-1:0];
        if (win_wr > WIN_W'(MAX_WINDOW))
            win_wr = WIN_W'(MAX_WINDOW);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WIN_W'(10);
            vpc_reg    <= 32'd13520;
            mode_reg   <= MODE_NONE;
            scale_reg  <= Q_ONE;
            slope_reg  <= Q_ONE;
            offset_reg <= '0;
            pcount_reg <= '0;
            pdeg_reg   <= 3'd2;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WINDOW:
                begin
                    if (cfg_data[WIN_W-1:0] != '0)
                        win_reg <= win_wr;
                end
                CFG_VPC:         vpc_reg    <= cfg_data;
                CFG_MODE:        mode_reg   <= cfg_data[2:0];
                CFG_SCALE:       scale_reg  <= cfg_data;
                CFG_SLOPE:       slope_reg  <= cfg_data;
                CFG_OFFSET:      offset_reg <= cfg_data;
                CFG_POINT_COUNT: pcount_reg <= cfg_data[3:0];
                CFG_POLY_DEGREE: pdeg_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Table loads from point and coefficient beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                raw_tab_reg[i]   <= '0;
                known_tab_reg[i] <= '0;
                coef_tab_reg[i]  <= '0;
            end
        end
        else if (accept && ({1'b0, in_data.entry_index} < 4'(MAX_POINTS)))
        begin
            if (in_data.opcode == OP_POINT)
            begin
                raw_tab_reg[in_data.entry_index[IDX_W-1:0]]   <= in_data.raw_point;
                known_tab_reg[in_data.entry_index[IDX_W-1:0]] <= in_data.known_point;
            end
            else if (in_data.opcode == OP_COEF)
            begin
                coef_tab_reg[in_data.entry_index[IDX_W-1:0]] <= in_data.coefficient;
            end
        end
    end

    // Ring memory: registered read of the slot about to be replaced
    always_ff @(posedge clk)
    begin
        if (ring_rd)
            ring_q_reg <= ring_mem[slot_eff];
        if (ring_we)
            ring_mem[slot_eff] <= sample_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        sample_next    = sample_reg;
        count_next     = count_reg;
        volt_next      = volt_reg;
        flag_next      = flag_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        hi_x_next      = hi_x_reg;
        hi_y_next      = hi_y_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        xp_next        = xp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ring_rd        = 1'b0;
        ring_we        = 1'b0;
        rd_idx         = idx_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dvd        = {23'b0, vnum[48:8]};
        div_dvs        = {28'b0, count_reg};
        wide           = '0;
        sat_r          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.opcode == OP_SAMPLE)
                begin
                    sample_next = in_data.sample[ADC_BITS-1:0];
                    ring_rd     = 1'b1;
                    flag_next   = 1'b0;
                    state_next  = S_RING;
                end
            end

            // Replace the oldest sample and update the running sum
            S_RING:
            begin
                ring_we  = 1'b1;
                sum_next = sum_reg - (full_reg ? SUM_W'(ring_q_reg) : '0)
                           + SUM_W'(sample_reg);
                if (slot_inc >= win_reg)
                begin
                    slot_next  = '0;
                    full_next  = 1'b1;
                    count_next = win_reg;
                end
                else
                begin
                    slot_next  = slot_inc[SLOT_W-1:0];
                    count_next = full_reg ? win_reg : slot_inc;
                end
                state_next = S_VMUL;
            end

            S_VMUL:
            begin
                mul_a      = MUL_W'(sum_reg);
                mul_b      = {1'b0, vpc_reg};
                state_next = S_VDIV;
            end

            S_VDIV:
            begin
                div_start  = 1'b1;
                state_next = S_VWAIT;
            end

            S_VWAIT:
            begin
                if (div_done)
                begin
                    if (div_q[63:31] != '0)
                    begin
                        volt_next = 32'h7FFF_FFFF;
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        volt_next = div_q[31:0];
                    end
                    state_next = S_MAP;
                end
            end

            S_MAP:
            begin
                res_next = volt_reg;
                case (mode_reg)
                    MODE_GAIN:
                    begin
                        mul_a      = v33;
                        mul_b      = {scale_reg[31], scale_reg};
                        state_next = S_M12;
                    end
                    MODE_LINEAR:
                    begin
                        mul_a      = v33;
                        mul_b      = {slope_reg[31], slope_reg};
                        state_next = S_M12;
                    end
                    MODE_PWL:
                    begin
                        state_next = (npts == '0) ? S_OUT : S_PL_FIRST;
                    end
                    MODE_POLY:
                    begin
                        acc_next   = '0;
                        xp_next    = Q_ONE;
                        idx_next   = '0;
                        state_next = S_P_CMUL;
                    end
                    default: state_next = S_OUT;
                endcase
            end

            S_M12:
            begin
                wide = mulq(mul_p);
                if (mode_reg == MODE_LINEAR)
                    wide = wide + 64'(offset_reg);
                sat_r      = sat32(wide);
                res_next   = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                state_next = S_OUT;
            end

            // Clamp below the first point
            S_PL_FIRST:
            begin
                rd_idx = '0;
                if (v33 <= 33'(rd_x))
                begin
                    res_next   = rd_y;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PL_LAST;
                end
            end

            // Clamp above the last point
            S_PL_LAST:
            begin
                rd_idx = IDX_W'(npts - 1'b1);
                if (v33 >= 33'(rd_x))
                begin
                    res_next   = rd_y;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_PL_SCAN;
                end
            end

            // Walk the table one entry a cycle for the first segment holding v
            S_PL_SCAN:
            begin
                if (idx_reg != '0 && v33 >= 33'(prev_x_reg) && v33 <= 33'(rd_x))
                begin
                    hi_x_next  = rd_x;
                    hi_y_next  = rd_y;
                    state_next = S_PL_DX;
                end
                else
                begin
                    prev_x_next = rd_x;
                    prev_y_next = rd_y;
                    if ({1'b0, idx_reg} == PCNT_W'(npts - 1'b1))
                    begin
                        res_next   = volt_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_PL_DX:
            begin
                if (dx == '0)
                begin
                    res_next   = prev_y_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_PL_DWAIT;
                end
                div_dvd = {2'b0, dv[31:0], 30'b0};
                div_dvs = dx[32:0];
            end

            S_PL_DWAIT:
            begin
                if (div_done)
                begin
                    t_next     = div_q[30:0];
                    state_next = S_PL_MUL;
                end
            end

            S_PL_MUL:
            begin
                mul_a      = {1'b0, ady};
                mul_b      = {2'b0, t_reg};
                state_next = S_PL_FIN;
            end

            S_PL_FIN:
            begin
                if (dy[32])
                    wide = 64'(prev_y_reg) - $signed(m_round);
                else
                    wide = 64'(prev_y_reg) + $signed(m_round);
                sat_r      = sat32(wide);
                res_next   = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                state_next = S_OUT;
            end

            // Horner-free power series: acc += c[i] * x^i
            S_P_CMUL:
            begin
                mul_a      = {rd_c[31], rd_c};
                mul_b      = {xp_reg[31], xp_reg};
                state_next = S_P_CACC;
            end

            S_P_CACC:
            begin
                wide      = 64'(acc_reg) + mulq(mul_p);
                sat_r     = sat32(wide);
                acc_next  = sat_r[31:0];
                flag_next = flag_reg | sat_r[32];
                if (idx_reg < pdeg_reg)
                begin
                    state_next = S_P_XMUL;
                end
                else
                begin
                    res_next   = sat_r[31:0];
                    state_next = S_OUT;
                end
            end

            S_P_XMUL:
            begin
                mul_a      = {xp_reg[31], xp_reg};
                mul_b      = v33;
                state_next = S_P_XUPD;
            end

            S_P_XUPD:
            begin
                sat_r      = sat32(mulq(mul_p));
                xp_next    = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                idx_next   = idx_reg + 1'b1;
                state_next = S_P_CMUL;
            end

            // Hand the result to the output register once it is free
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.calibrated_value = res_reg;
                    out_data_next.voltage          = volt_reg;
                    out_data_next.saturated        = flag_reg;
                    state_next                     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // A window write restarts the average
        if (cfg_write && cfg_index == CFG_WINDOW && cfg_data[WIN_W-1:0] != '0)
        begin
            sum_next  = '0;
            slot_next = '0;
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        count_reg    <= count_next;
        volt_reg     <= volt_next;
        flag_reg     <= flag_next;
        res_reg      <= res_next;
        idx_reg      <= idx_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        hi_x_reg     <= hi_x_next;
        hi_y_reg     <= hi_y_next;
        t_reg        <= t_next;
        acc_reg      <= acc_next;
        xp_reg       <= xp_next;
        out_data_reg <= out_data_next;
    end

endmodule
